// ----- rtl/rsc_pkg.sv -----
// Shared types, constants and helper functions for the radix string converter.
// Depends on nothing; imported by radix_string_converter.
package rsc_pkg;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_READ = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    // Configuration register indexes
    localparam logic [1:0] CFG_IN_RADIX  = 2'd0;
    localparam logic [1:0] CFG_OUT_RADIX = 2'd1;

    localparam int         DIGIT_DEPTH   = 32;
    localparam logic [5:0] RADIX_MIN     = 6'd2;
    localparam logic [5:0] RADIX_MAX     = 6'd36;
    localparam logic [5:0] RADIX_RESET   = 6'd10;
    localparam logic [5:0] DEC_RADIX     = 6'd10;
    localparam logic [5:0] NO_DIGIT      = 6'd63;   // never below any legal radix

    localparam logic [7:0] ASCII_ZERO    = 8'd48;
    localparam logic [7:0] ASCII_NINE    = 8'd57;
    localparam logic [7:0] ASCII_A_UP    = 8'd65;
    localparam logic [7:0] ASCII_Z_UP    = 8'd90;
    localparam logic [7:0] ASCII_A_LOW   = 8'd97;
    localparam logic [7:0] ASCII_Z_LOW   = 8'd122;
    localparam logic [7:0] LETTER_OFS    = 8'd55;   // 'A' - 10

    // Force a radix register into 2..36
    function automatic logic [5:0] clamp_radix(input logic [5:0] r);
        logic [5:0] res;
        if (r < RADIX_MIN) begin
            res = RADIX_MIN;
        end else if (r > RADIX_MAX) begin
            res = RADIX_MAX;
        end else begin
            res = r;
        end
        return res;
    endfunction

    // Digit value of a character, NO_DIGIT if it is no digit character
    function automatic logic [5:0] char_value(input logic [7:0] c);
        logic [7:0] v;
        if (c inside {[ASCII_ZERO:ASCII_NINE]}) begin
            v = c - ASCII_ZERO;
        end else if (c inside {[ASCII_A_UP:ASCII_Z_UP]}) begin
            v = c - ASCII_A_UP + 8'(DEC_RADIX);
        end else if (c inside {[ASCII_A_LOW:ASCII_Z_LOW]}) begin
            v = c - ASCII_A_LOW + 8'(DEC_RADIX);
        end else begin
            v = 8'(NO_DIGIT);
        end
        return v[5:0];
    endfunction

    // Digit value to uppercase ASCII
    function automatic logic [7:0] digit_ascii(input logic [5:0] d);
        logic [7:0] code;
        if (d < DEC_RADIX) begin
            code = {2'b00, d} + ASCII_ZERO;
        end else begin
            code = {2'b00, d} + LETTER_OFS;
        end
        return code;
    endfunction

endpackage

// ----- rtl/radix_string_converter.sv -----
// Radix string converter: a non-final character is folded in while busy stays low.
// Final character: each output digit comes from a bit-serial restoring divide over
// VALUE_BITS bits (one divider step per cycle), then a digit store read and a strobe.
// Results cannot be stalled.
// i_rst_n is synchronous, active low: clears sequencer, accumulator, flags, count;
// both radix registers return to 10. Digit store is not cleared.
module radix_string_converter #(
    parameter int VALUE_BITS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // character beats
    input  logic       i_start,
    output logic       o_busy,
    input  logic [7:0] i_char_code,
    input  logic       i_last_char,
    // digit beats
    output logic       o_valid,
    output logic [7:0] o_digit_code,
    output logic       o_last_digit,
    output logic       o_bad_digit,
    // configuration writes
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [5:0] i_cfg_data
);
    import rsc_pkg::*;

    localparam int BW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
    localparam logic [BW-1:0] LAST_BIT = BW'(VALUE_BITS - 1);
    localparam int PW = $clog2(DIGIT_DEPTH);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DIGIT_DEPTH - 1);

    t_state                  r_state, n_state;
    logic [5:0]              r_in_radix, r_out_radix;
    logic [VALUE_BITS-1:0]   r_accum, n_accum;
    logic [VALUE_BITS-1:0]   r_val, n_val;
    logic [5:0]              r_rem, n_rem;
    logic [BW-1:0]           r_bit, n_bit;
    logic [PW:0]             r_cnt, n_cnt;
    logic [PW-1:0]           r_ptr, n_ptr;
    logic                    r_bad, n_bad;
    logic [5:0]              r_rd_data;
    logic [5:0]              mem [DIGIT_DEPTH];

    logic [5:0]              w_rin, w_rout, w_dval;
    logic                    w_dok;
    logic [VALUE_BITS+5:0]   w_prod;
    logic [VALUE_BITS-1:0]   w_horner;
    logic [6:0]              w_rem_sh, w_rem_nx;
    logic                    w_ge;
    logic [VALUE_BITS-1:0]   w_quo;
    logic                    w_mem_we;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = (r_state != S_IDLE);

    // Radix registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_radix  <= RADIX_RESET;
            r_out_radix <= RADIX_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_IN_RADIX:  r_in_radix  <= i_cfg_data;
                CFG_OUT_RADIX: r_out_radix <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Horner step: accum * radix + digit, wraps at VALUE_BITS
    assign w_rin    = clamp_radix(r_in_radix);
    assign w_rout   = clamp_radix(r_out_radix);
    assign w_dval   = char_value(i_char_code);
    assign w_dok    = (w_dval < w_rin);
    assign w_prod   = r_accum * w_rin;
    assign w_horner = w_prod[VALUE_BITS-1:0] + VALUE_BITS'(w_dval);

    // Bit-serial divider step: one quotient bit per cycle
    assign w_rem_sh = {r_rem, r_val[VALUE_BITS-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, w_rout});
    assign w_rem_nx = w_ge ? (w_rem_sh - {1'b0, w_rout}) : w_rem_sh;
    assign w_quo    = {r_val[VALUE_BITS-2:0], w_ge};

    // Sequencer
    always_comb begin
        n_state  = r_state;
        n_accum  = r_accum;
        n_val    = r_val;
        n_rem    = r_rem;
        n_bit    = r_bit;
        n_cnt    = r_cnt;
        n_ptr    = r_ptr;
        n_bad    = r_bad;
        w_mem_we = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (w_dok) begin
                        n_accum = w_horner;
                    end else begin
                        n_bad = 1'b1;
                    end
                    if (i_last_char) begin
                        n_val   = w_dok ? w_horner : r_accum;
                        n_accum = '0;
                        n_rem   = '0;
                        n_bit   = '0;
                        n_cnt   = '0;
                        n_state = S_DIV;
                    end
                end
            end
            S_DIV: begin
                n_val = w_quo;
                n_rem = w_rem_nx[5:0];
                n_bit = r_bit + 1'b1;
                if (r_bit == LAST_BIT) begin
                    // remainder is the next digit, least significant first
                    w_mem_we = 1'b1;
                    n_cnt    = r_cnt + 1'b1;
                    n_rem    = '0;
                    n_bit    = '0;
                    if (w_quo == '0 || r_cnt[PW-1:0] == LAST_SLOT) begin
                        n_ptr   = r_cnt[PW-1:0];
                        n_state = S_READ;
                    end
                end
            end
            S_READ: begin
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (r_ptr == '0) begin
                    n_cnt   = '0;
                    n_bad   = 1'b0;
                    n_state = S_IDLE;
                end else begin
                    n_ptr   = r_ptr - 1'b1;
                    n_state = S_READ;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_accum <= '0;
            r_cnt   <= '0;
            r_bad   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_accum <= n_accum;
            r_cnt   <= n_cnt;
            r_bad   <= n_bad;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
        r_rem <= n_rem;
        r_bit <= n_bit;
        r_ptr <= n_ptr;
    end

    // Digit store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[r_cnt[PW-1:0]] <= w_rem_nx[5:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_READ) begin
            r_rd_data <= mem[r_ptr];
        end
    end

    // Output beat
    assign o_valid      = (r_state == S_EMIT);
    assign o_digit_code = digit_ascii(r_rd_data);
    assign o_last_digit = (r_state == S_EMIT) && (r_ptr == '0);
    assign o_bad_digit  = r_bad;

`ifndef SYNTH
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy)
        else $error("digit beat outside a conversion");
    a_last_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_last_char) |=> (r_state == S_DIV))
        else $error("final character did not start division");
    a_mid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && !i_last_char) |=> !o_busy)
        else $error("non-final character left block busy");
    a_last_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_digit) |=> (!o_busy && r_cnt == '0 && !r_bad))
        else $error("state not cleared after final digit");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (PW+1)'(DIGIT_DEPTH))
        else $error("digit count overflow");
`endif

endmodule
